[design/ep0r_pkg.sv]
// ----------------------------------------------------------------------------
// ep0r_pkg
// Shared types, codes and helper functions of the EP0 request engine.
// ----------------------------------------------------------------------------
package ep0r_pkg;

  // Packet size of endpoint zero and number of endpoints with halt flags
  localparam logic [15:0] EP0_PACKET = 16'd64;
  localparam int unsigned EP_COUNT   = 16;

  // Event opcodes
  localparam logic [2:0] OP_BUS_RESET = 3'd0;
  localparam logic [2:0] OP_SUSPEND   = 3'd1;
  localparam logic [2:0] OP_RESUME    = 3'd2;
  localparam logic [2:0] OP_SETUP     = 3'd3;
  localparam logic [2:0] OP_OUT_DONE  = 3'd4;
  localparam logic [2:0] OP_IN_DONE   = 3'd5;
  localparam logic [2:0] OP_SOF       = 3'd6;

  // Action codes
  localparam logic [3:0] ACT_NONE        = 4'd0;
  localparam logic [3:0] ACT_STALL       = 4'd1;
  localparam logic [3:0] ACT_CLEAR_STALL = 4'd2;
  localparam logic [3:0] ACT_SEND        = 4'd3;
  localparam logic [3:0] ACT_CONT_SEND   = 4'd4;
  localparam logic [3:0] ACT_RECEIVE     = 4'd5;
  localparam logic [3:0] ACT_STATUS_IN   = 4'd6;
  localparam logic [3:0] ACT_STATUS_OUT  = 4'd7;
  localparam logic [3:0] ACT_SET_ADDR    = 4'd8;
  localparam logic [3:0] ACT_CLS_SETUP   = 4'd9;
  localparam logic [3:0] ACT_CLS_INIT    = 4'd10;
  localparam logic [3:0] ACT_CLS_DEINIT  = 4'd11;
  localparam logic [3:0] ACT_CLS_DATA    = 4'd12;
  localparam logic [3:0] ACT_CLS_SOF     = 4'd13;
  localparam logic [3:0] ACT_RX_READY    = 4'd14;
  localparam logic [3:0] ACT_TX_SENT     = 4'd15;

  // Device states
  localparam logic [1:0] ST_DEFAULT    = 2'd0;
  localparam logic [1:0] ST_ADDRESSED  = 2'd1;
  localparam logic [1:0] ST_CONFIGURED = 2'd2;
  localparam logic [1:0] ST_SUSPENDED  = 2'd3;

  // EP0 stages
  localparam logic [2:0] STG_IDLE       = 3'd0;
  localparam logic [2:0] STG_SETUP      = 3'd1;
  localparam logic [2:0] STG_DATA_IN    = 3'd2;
  localparam logic [2:0] STG_DATA_OUT   = 3'd3;
  localparam logic [2:0] STG_STATUS_IN  = 3'd4;
  localparam logic [2:0] STG_STATUS_OUT = 3'd5;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC      = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;

  // Configuration register indexes
  localparam logic [2:0] REG_SELF_POWERED = 3'd0;
  localparam logic [2:0] REG_HIGH_SPEED   = 3'd1;
  localparam logic [2:0] REG_IN_USED      = 3'd2;
  localparam logic [2:0] REG_OUT_USED     = 3'd3;
  localparam logic [2:0] REG_MAX_IF       = 3'd4;
  localparam logic [2:0] REG_MAX_CFG      = 3'd5;

  // Event class found by the front part
  typedef enum logic [3:0] {
    CLS_NOP,
    CLS_BUS_RESET,
    CLS_SUSPEND,
    CLS_RESUME,
    CLS_SOF,
    CLS_OUT_DONE,
    CLS_IN_DONE,
    CLS_SETUP_BAD_RECIP,
    CLS_SETUP_RESERVED,
    CLS_SETUP_IFACE,
    CLS_SETUP_CLASS,
    CLS_SETUP_DEVICE,
    CLS_SETUP_EP
  } cls_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    cls_t        cls;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic [3:0]  epn;
    logic        class_ok;
    logic        desc_present;
    logic [15:0] desc_length;
  } item_t;

  // Configuration registers
  typedef struct packed {
    logic        self_powered;
    logic        high_speed;
    logic [15:0] in_used_mask;
    logic [15:0] out_used_mask;
    logic [7:0]  max_interfaces;
    logic [7:0]  max_configurations;
  } cfg_t;

  // One result word and the list of results of one item
  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  addr;
    logic [15:0] count;
    logic [15:0] reply;
  } res_word_t;

  typedef struct packed {
    res_word_t [3:0] w;
    logic [2:0]      n;
  } res_list_t;

  // Append a result word to a list, keeping at most four
  function automatic res_list_t push_res(res_list_t l, logic [3:0] a, logic [7:0] ad,
                                         logic [15:0] c, logic [15:0] r);
    res_list_t o;
    o = l;
    if (l.n < 3'd4) begin
      o.w[l.n[1:0]] = '{action: a, addr: ad, count: c, reply: r};
      o.n = l.n + 3'd1;
    end
    return o;
  endfunction

  // Request error: stall IN then OUT of endpoint zero
  function automatic res_list_t stall_pair(res_list_t l);
    res_list_t o;
    o = push_res(l, ACT_STALL, 8'h80, 16'd0, 16'd0);
    o = push_res(o, ACT_STALL, 8'h00, 16'd0, 16'd0);
    return o;
  endfunction

  function automatic logic [15:0] min16(logic [15:0] a, logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  // Halt flag of an endpoint address: OUT in the low half, IN in the high half
  function automatic logic [31:0] halt_bit(logic [7:0] ep);
    logic [31:0] b;
    b = 32'd0;
    if (ep[3:0] != 4'd0 && 32'(ep[3:0]) < EP_COUNT) begin
      if (ep[7]) b[5'(ep[3:0]) + 5'd16] = 1'b1;
      else       b[5'(ep[3:0])] = 1'b1;
    end
    return b;
  endfunction

endpackage

[design/ep0r_front.sv]
// ----------------------------------------------------------------------------
// ep0r_front
// Accepts event items, classifies them and holds them for the queue.
// ----------------------------------------------------------------------------
module ep0r_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_request_type,
  input  logic [7:0]          in_request_code,
  input  logic [15:0]         in_request_value,
  input  logic [15:0]         in_request_index,
  input  logic [15:0]         in_request_length,
  input  logic [3:0]          in_endpoint_number,
  input  logic                in_class_ok,
  input  logic                in_desc_present,
  input  logic [15:0]         in_desc_length,
  output logic                fr_valid,
  input  logic                fr_ready,
  output ep0r_pkg::item_t     fr_item
);

  logic            vld_r;
  ep0r_pkg::item_t item_r;
  ep0r_pkg::cls_t  cls;

  // Classify the event from opcode and request type
  always_comb begin
    unique case (in_op)
      ep0r_pkg::OP_BUS_RESET: cls = ep0r_pkg::CLS_BUS_RESET;
      ep0r_pkg::OP_SUSPEND:   cls = ep0r_pkg::CLS_SUSPEND;
      ep0r_pkg::OP_RESUME:    cls = ep0r_pkg::CLS_RESUME;
      ep0r_pkg::OP_OUT_DONE:  cls = ep0r_pkg::CLS_OUT_DONE;
      ep0r_pkg::OP_IN_DONE:   cls = ep0r_pkg::CLS_IN_DONE;
      ep0r_pkg::OP_SOF:       cls = ep0r_pkg::CLS_SOF;
      ep0r_pkg::OP_SETUP: begin
        priority if (in_request_type[4:0] > 5'd2) cls = ep0r_pkg::CLS_SETUP_BAD_RECIP;
        else if (in_request_type[6:5] == 2'd3)   cls = ep0r_pkg::CLS_SETUP_RESERVED;
        else if (in_request_type[4:0] == 5'd1)   cls = ep0r_pkg::CLS_SETUP_IFACE;
        else if (in_request_type[6:5] != 2'd0)   cls = ep0r_pkg::CLS_SETUP_CLASS;
        else if (in_request_type[4:0] == 5'd0)   cls = ep0r_pkg::CLS_SETUP_DEVICE;
        else                                     cls = ep0r_pkg::CLS_SETUP_EP;
      end
      default: cls = ep0r_pkg::CLS_NOP;
    endcase
  end

  // Holding register: a new item enters as the old one leaves
  assign in_ready = !vld_r || fr_ready;
  assign fr_valid = vld_r;
  assign fr_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{cls: cls, rtype: in_request_type, code: in_request_code,
                  value: in_request_value, index: in_request_index,
                  length: in_request_length, epn: in_endpoint_number,
                  class_ok: in_class_ok, desc_present: in_desc_present,
                  desc_length: in_desc_length};
    end
  end

endmodule

[design/ep0r_queue.sv]
// ----------------------------------------------------------------------------
// ep0r_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module ep0r_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ep0r_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ep0r_pkg::item_t rd_item
);

  ep0r_pkg::item_t mem_r [2];
  logic            wptr_r;
  logic            rptr_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_item;
  end

endmodule

[design/ep0r_exec.sv]
// ----------------------------------------------------------------------------
// ep0r_exec
// Carries out one classified item: updates the device and EP0 state and
// delivers its result words one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ep0r_exec (
  input  logic               clk,
  input  logic               rst_n,
  input  ep0r_pkg::cfg_t     cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  ep0r_pkg::item_t    q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_action,
  output logic [7:0]         out_endpoint_address,
  output logic [15:0]        out_byte_count,
  output logic [15:0]        out_reply_word,
  output logic [1:0]         out_device_state_out,
  output logic               out_last
);

  // Device and endpoint state
  logic [1:0]  dev_r, dev_nxt;
  logic [1:0]  saved_r, saved_nxt;
  logic [2:0]  stage_r, stage_nxt;
  logic [7:0]  cfgval_r, cfgval_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic        rwake_r, rwake_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] inrem_r, inrem_nxt;
  logic [15:0] intot_r, intot_nxt;
  logic [15:0] outrem_r, outrem_nxt;
  logic [31:0] halt_r, halt_nxt;
  logic        test_r, test_nxt;

  // Result buffer
  ep0r_pkg::res_list_t list_r, list_nxt;
  logic [1:0]          idx_r;
  logic                busy_r;
  logic                take;
  logic                done;

  // Work out the result words and the next state of the item at the queue head
  always_comb begin
    ep0r_pkg::res_list_t l;
    ep0r_pkg::item_t     it;
    logic [7:0]          ep;
    logic                ep0;
    logic                susp;
    logic                conf;
    logic [7:0]          dtype;
    logic                dok;
    logic [7:0]          cv;
    logic [15:0]         mask;
    l  = '0;
    it = q_item;
    dev_nxt = dev_r; saved_nxt = saved_r; stage_nxt = stage_r;
    cfgval_nxt = cfgval_r; addr_nxt = addr_r; rwake_nxt = rwake_r;
    exp_nxt = exp_r; inrem_nxt = inrem_r; intot_nxt = intot_r;
    outrem_nxt = outrem_r; halt_nxt = halt_r; test_nxt = test_r;
    ep    = it.index[7:0];
    ep0   = (ep == 8'h00) || (ep == 8'h80);
    susp  = dev_r == ep0r_pkg::ST_SUSPENDED;
    conf  = dev_r == ep0r_pkg::ST_CONFIGURED;
    dtype = it.value[15:8];
    cv    = it.value[7:0];
    mask  = ep[7] ? cfg.in_used_mask : cfg.out_used_mask;
    dok   = 1'b0;

    unique case (it.cls)
      ep0r_pkg::CLS_BUS_RESET: begin
        if (cfgval_r != 8'd0)
          l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0, {8'd0, cfgval_r});
        dev_nxt = ep0r_pkg::ST_DEFAULT; saved_nxt = ep0r_pkg::ST_DEFAULT;
        stage_nxt = ep0r_pkg::STG_IDLE; cfgval_nxt = 8'd0; addr_nxt = 7'd0;
        rwake_nxt = 1'b0; exp_nxt = 16'd0; inrem_nxt = 16'd0; intot_nxt = 16'd0;
        outrem_nxt = 16'd0; halt_nxt = 32'd0; test_nxt = 1'b0;
      end

      ep0r_pkg::CLS_SUSPEND: begin
        if (!susp) saved_nxt = dev_r;
        dev_nxt = ep0r_pkg::ST_SUSPENDED;
      end

      ep0r_pkg::CLS_RESUME: begin
        if (susp) dev_nxt = saved_r;
      end

      ep0r_pkg::CLS_SOF: begin
        if (conf) l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_SOF, 8'h00, 16'd0, 16'd0);
      end

      ep0r_pkg::CLS_OUT_DONE: begin
        if (it.epn != 4'd0) begin
          if (conf)
            l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_DATA, {4'd0, it.epn}, 16'd0, 16'd0);
        end else if (stage_r == ep0r_pkg::STG_DATA_OUT) begin
          if (outrem_r > ep0r_pkg::EP0_PACKET) begin
            outrem_nxt = outrem_r - ep0r_pkg::EP0_PACKET;
            l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_RECEIVE, 8'h00,
                                   ep0r_pkg::min16(outrem_nxt, ep0r_pkg::EP0_PACKET), 16'd0);
          end else begin
            if (conf) l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_RX_READY, 8'h00, 16'd0, 16'd0);
            stage_nxt = ep0r_pkg::STG_STATUS_IN;
            l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
          end
        end else if (stage_r == ep0r_pkg::STG_STATUS_OUT) begin
          stage_nxt = ep0r_pkg::STG_IDLE;
          l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, 8'h00, 16'd0, 16'd0);
        end
      end

      ep0r_pkg::CLS_IN_DONE: begin
        if (it.epn != 4'd0) begin
          if (conf)
            l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_DATA, {4'h8, it.epn}, 16'd0, 16'd0);
        end else begin
          if (stage_r == ep0r_pkg::STG_DATA_IN) begin
            if (inrem_r > ep0r_pkg::EP0_PACKET) begin
              inrem_nxt = inrem_r - ep0r_pkg::EP0_PACKET;
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CONT_SEND, 8'h80, inrem_nxt, 16'd0);
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_RECEIVE, 8'h00, 16'd0, 16'd0);
            end else if ((intot_r % ep0r_pkg::EP0_PACKET) == 16'd0 &&
                         intot_r >= ep0r_pkg::EP0_PACKET && intot_r < exp_r) begin
              // Transfer ended on a packet boundary short of the request
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CONT_SEND, 8'h80, 16'd0, 16'd0);
              exp_nxt = 16'd0;
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_RECEIVE, 8'h00, 16'd0, 16'd0);
            end else begin
              if (conf) l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_TX_SENT, 8'h80, 16'd0, 16'd0);
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
              stage_nxt = ep0r_pkg::STG_STATUS_OUT;
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_OUT, 8'h00, 16'd0, 16'd0);
            end
          end else if (stage_r == ep0r_pkg::STG_STATUS_IN || stage_r == ep0r_pkg::STG_IDLE) begin
            l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
          end
          test_nxt = 1'b0;
        end
      end

      ep0r_pkg::CLS_SETUP_BAD_RECIP, ep0r_pkg::CLS_SETUP_RESERVED,
      ep0r_pkg::CLS_SETUP_IFACE, ep0r_pkg::CLS_SETUP_CLASS,
      ep0r_pkg::CLS_SETUP_DEVICE, ep0r_pkg::CLS_SETUP_EP: begin
        stage_nxt = ep0r_pkg::STG_SETUP;
        exp_nxt   = it.length;
        unique case (it.cls)
          ep0r_pkg::CLS_SETUP_BAD_RECIP: begin
            l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, {it.rtype[7], 7'd0}, 16'd0, 16'd0);
          end

          ep0r_pkg::CLS_SETUP_RESERVED: l = ep0r_pkg::stall_pair(l);

          ep0r_pkg::CLS_SETUP_IFACE, ep0r_pkg::CLS_SETUP_CLASS: begin
            if (it.cls == ep0r_pkg::CLS_SETUP_IFACE && (susp || ep > cfg.max_interfaces)) begin
              l = ep0r_pkg::stall_pair(l);
            end else begin
              // Hand the request to the class layer
              l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_SETUP, 8'h00, 16'd0, 16'd0);
              if (it.class_ok && it.length != 16'd0 && !it.rtype[7]) begin
                stage_nxt  = ep0r_pkg::STG_DATA_OUT;
                outrem_nxt = it.length;
                l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_RECEIVE, 8'h00,
                                       ep0r_pkg::min16(it.length, ep0r_pkg::EP0_PACKET), 16'd0);
              end
              if (it.cls == ep0r_pkg::CLS_SETUP_IFACE && it.length == 16'd0 && it.class_ok) begin
                stage_nxt = ep0r_pkg::STG_STATUS_IN;
                l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
              end
            end
          end

          ep0r_pkg::CLS_SETUP_DEVICE: begin
            unique case (it.code)
              ep0r_pkg::REQ_GET_DESC: begin
                unique case (dtype)
                  8'd1, 8'd2: dok = 1'b1;
                  8'd3:       dok = it.value[7:0] <= 8'd5;
                  8'd6, 8'd7: dok = cfg.high_speed;
                  default:    dok = 1'b0;
                endcase
                if (!dok || !it.desc_present || (it.desc_length == 16'd0 && it.length != 16'd0)) begin
                  l = ep0r_pkg::stall_pair(l);
                end else if (it.length == 16'd0) begin
                  stage_nxt = ep0r_pkg::STG_STATUS_IN;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                end else begin
                  stage_nxt = ep0r_pkg::STG_DATA_IN;
                  inrem_nxt = ep0r_pkg::min16(it.desc_length, it.length);
                  intot_nxt = inrem_nxt;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_SEND, 8'h80, inrem_nxt, 16'd0);
                end
              end

              ep0r_pkg::REQ_SET_ADDRESS: begin
                if (conf || it.index != 16'd0 || it.length != 16'd0 || it.value > 16'h007F) begin
                  l = ep0r_pkg::stall_pair(l);
                end else begin
                  addr_nxt = it.value[6:0];
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_SET_ADDR, 8'h00, 16'd0,
                                         {9'd0, it.value[6:0]});
                  stage_nxt = ep0r_pkg::STG_STATUS_IN;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                  dev_nxt = (it.value[6:0] != 7'd0) ? ep0r_pkg::ST_ADDRESSED
                                                   : ep0r_pkg::ST_DEFAULT;
                end
              end

              ep0r_pkg::REQ_SET_CONFIG: begin
                if (cv > cfg.max_configurations) begin
                  l = ep0r_pkg::stall_pair(l);
                end else if (dev_r == ep0r_pkg::ST_ADDRESSED) begin
                  if (cv == 8'd0) begin
                    stage_nxt = ep0r_pkg::STG_STATUS_IN;
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                  end else begin
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_INIT, 8'h00, 16'd0, {8'd0, cv});
                    if (!it.class_ok) begin
                      l = ep0r_pkg::stall_pair(l);
                    end else begin
                      cfgval_nxt = cv;
                      dev_nxt    = ep0r_pkg::ST_CONFIGURED;
                      stage_nxt  = ep0r_pkg::STG_STATUS_IN;
                      l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                    end
                  end
                end else if (conf) begin
                  if (cv == 8'd0) begin
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0,
                                           {8'd0, cfgval_r});
                    cfgval_nxt = 8'd0;
                    dev_nxt    = ep0r_pkg::ST_ADDRESSED;
                    stage_nxt  = ep0r_pkg::STG_STATUS_IN;
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                  end else if (cv != cfgval_r) begin
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0,
                                           {8'd0, cfgval_r});
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_INIT, 8'h00, 16'd0, {8'd0, cv});
                    if (!it.class_ok) begin
                      cfgval_nxt = 8'd0;
                      dev_nxt    = ep0r_pkg::ST_ADDRESSED;
                      l = ep0r_pkg::stall_pair(l);
                    end else begin
                      cfgval_nxt = cv;
                      stage_nxt  = ep0r_pkg::STG_STATUS_IN;
                      l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                    end
                  end else begin
                    stage_nxt = ep0r_pkg::STG_STATUS_IN;
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                  end
                end else begin
                  l = ep0r_pkg::stall_pair(l);
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0, {8'd0, cv});
                end
              end

              ep0r_pkg::REQ_GET_CONFIG: begin
                if (it.length != 16'd1 || susp) begin
                  l = ep0r_pkg::stall_pair(l);
                end else begin
                  stage_nxt = ep0r_pkg::STG_DATA_IN;
                  inrem_nxt = 16'd1;
                  intot_nxt = 16'd1;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_SEND, 8'h80, 16'd1,
                                         conf ? {8'd0, cfgval_r} : 16'd0);
                end
              end

              ep0r_pkg::REQ_GET_STATUS: begin
                if (it.length != 16'd2 || susp) begin
                  l = ep0r_pkg::stall_pair(l);
                end else begin
                  stage_nxt = ep0r_pkg::STG_DATA_IN;
                  inrem_nxt = 16'd2;
                  intot_nxt = 16'd2;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_SEND, 8'h80, 16'd2,
                                         {14'd0, rwake_r, cfg.self_powered});
                end
              end

              ep0r_pkg::REQ_SET_FEATURE: begin
                if (it.value == 16'd1 || it.value == 16'd2) begin
                  if (it.value == 16'd1) rwake_nxt = 1'b1;
                  else                   test_nxt  = 1'b1;
                  stage_nxt = ep0r_pkg::STG_STATUS_IN;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                end else begin
                  l = ep0r_pkg::stall_pair(l);
                end
              end

              ep0r_pkg::REQ_CLEAR_FEATURE: begin
                if (!susp && it.value == 16'd1) begin
                  rwake_nxt = 1'b0;
                  stage_nxt = ep0r_pkg::STG_STATUS_IN;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                end else begin
                  l = ep0r_pkg::stall_pair(l);
                end
              end

              default: l = ep0r_pkg::stall_pair(l);
            endcase
          end

          default: begin
            // Endpoint requests
            if (it.code == ep0r_pkg::REQ_SET_FEATURE || it.code == ep0r_pkg::REQ_CLEAR_FEATURE) begin
              if (dev_r == ep0r_pkg::ST_ADDRESSED) begin
                if (!ep0) begin
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, ep, 16'd0, 16'd0);
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
                end else begin
                  l = ep0r_pkg::stall_pair(l);
                end
              end else if (conf) begin
                if (it.code == ep0r_pkg::REQ_SET_FEATURE) begin
                  if (it.value == 16'd0 && !ep0 && it.length == 16'd0) begin
                    halt_nxt = halt_r | ep0r_pkg::halt_bit(ep);
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STALL, ep, 16'd0, 16'd0);
                  end
                  stage_nxt = ep0r_pkg::STG_STATUS_IN;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                end else if (it.value == 16'd0) begin
                  if (ep[6:0] != 7'd0) begin
                    halt_nxt = halt_r & ~ep0r_pkg::halt_bit(ep);
                    l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_CLEAR_STALL, ep, 16'd0, 16'd0);
                  end
                  stage_nxt = ep0r_pkg::STG_STATUS_IN;
                  l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
                end
              end else begin
                l = ep0r_pkg::stall_pair(l);
              end
            end else if (it.code == ep0r_pkg::REQ_GET_STATUS) begin
              if ((dev_r == ep0r_pkg::ST_ADDRESSED && !ep0) ||
                  (conf && !mask[ep[3:0]]) ||
                  (dev_r != ep0r_pkg::ST_ADDRESSED && !conf)) begin
                l = ep0r_pkg::stall_pair(l);
              end else begin
                stage_nxt = ep0r_pkg::STG_DATA_IN;
                inrem_nxt = 16'd2;
                intot_nxt = 16'd2;
                l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_SEND, 8'h80, 16'd2,
                      {15'd0, conf && !ep0 && ((halt_r & ep0r_pkg::halt_bit(ep)) != 32'd0)});
              end
            end else begin
              l = ep0r_pkg::stall_pair(l);
            end
          end
        endcase
      end

      default: ;
    endcase

    // An event with nothing to do still answers once
    if (l.n == 3'd0) l = ep0r_pkg::push_res(l, ep0r_pkg::ACT_NONE, 8'h00, 16'd0, 16'd0);
    list_nxt = l;
  end

  // Result delivery
  assign out_valid            = busy_r;
  assign out_last             = {1'b0, idx_r} == list_r.n - 3'd1;
  assign out_action           = list_r.w[idx_r].action;
  assign out_endpoint_address = list_r.w[idx_r].addr;
  assign out_byte_count       = list_r.w[idx_r].count;
  assign out_reply_word       = list_r.w[idx_r].reply;
  assign out_device_state_out = dev_r;

  assign done    = out_valid && out_ready && out_last;
  assign q_ready = !busy_r || done;
  assign take    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; idx_r <= 2'd0;
      dev_r <= ep0r_pkg::ST_DEFAULT; saved_r <= ep0r_pkg::ST_DEFAULT;
      stage_r <= ep0r_pkg::STG_IDLE; cfgval_r <= 8'd0; addr_r <= 7'd0;
      rwake_r <= 1'b0; exp_r <= 16'd0; inrem_r <= 16'd0; intot_r <= 16'd0;
      outrem_r <= 16'd0; halt_r <= 32'd0; test_r <= 1'b0;
    end else if (take) begin
      busy_r <= 1'b1; idx_r <= 2'd0;
      dev_r <= dev_nxt; saved_r <= saved_nxt; stage_r <= stage_nxt;
      cfgval_r <= cfgval_nxt; addr_r <= addr_nxt; rwake_r <= rwake_nxt;
      exp_r <= exp_nxt; inrem_r <= inrem_nxt; intot_r <= intot_nxt;
      outrem_r <= outrem_nxt; halt_r <= halt_nxt; test_r <= test_nxt;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) list_r <= list_nxt;
  end

endmodule

[design/usb_device_ep0_request_engine_core.sv]
// ----------------------------------------------------------------------------
// usb_device_ep0_request_engine_core
// Control endpoint zero request engine of a USB device.
// ----------------------------------------------------------------------------
// Usage:
//   Events (bus reset, suspend, resume, setup, OUT done, IN done, SOF) enter
//   on the in_ valid/ready channel, one item per event. Each item yields one
//   to four action words on the out_ channel; out_last marks the final one.
//   The user writes the configuration registers on the cfg_ port only while
//   the block is idle; the block itself does not enforce it.
// Data path:
//   An item is classified in the front register, passes a two-entry queue
//   and is taken into the result register of the back part, which delivers
//   one action word per cycle while out_ready is high; the front keeps
//   taking items meanwhile until the queue is full.
// Reset:
//   Synchronous, active low. State returns to default device, idle EP0 and
//   reset register values; queued items are discarded.
// Stalls:
//   When out_ready is low the current word holds, the queue fills and in_ready
//   then drops until words are taken again.
// ----------------------------------------------------------------------------
module usb_device_ep0_request_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_request_type,
  input  logic [7:0]  in_request_code,
  input  logic [15:0] in_request_value,
  input  logic [15:0] in_request_index,
  input  logic [15:0] in_request_length,
  input  logic [3:0]  in_endpoint_number,
  input  logic        in_class_ok,
  input  logic        in_desc_present,
  input  logic [15:0] in_desc_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_action,
  output logic [7:0]  out_endpoint_address,
  output logic [15:0] out_byte_count,
  output logic [15:0] out_reply_word,
  output logic [1:0]  out_device_state_out,
  output logic        out_last
);

  ep0r_pkg::cfg_t  cfg_r;
  logic            fr_valid, fr_ready;
  ep0r_pkg::item_t fr_item;
  logic            q_valid, q_ready;
  ep0r_pkg::item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{self_powered: 1'b0, high_speed: 1'b0, in_used_mask: 16'd1,
                 out_used_mask: 16'd1, max_interfaces: 8'd1, max_configurations: 8'd1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        ep0r_pkg::REG_SELF_POWERED: cfg_r.self_powered       <= cfg_wdata[0];
        ep0r_pkg::REG_HIGH_SPEED:   cfg_r.high_speed         <= cfg_wdata[0];
        ep0r_pkg::REG_IN_USED:      cfg_r.in_used_mask       <= cfg_wdata;
        ep0r_pkg::REG_OUT_USED:     cfg_r.out_used_mask      <= cfg_wdata;
        ep0r_pkg::REG_MAX_IF:       cfg_r.max_interfaces     <= cfg_wdata[7:0];
        ep0r_pkg::REG_MAX_CFG:      cfg_r.max_configurations <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ep0r_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_request_type, .in_request_code,
    .in_request_value, .in_request_index, .in_request_length, .in_endpoint_number,
    .in_class_ok, .in_desc_present, .in_desc_length,
    .fr_valid, .fr_ready, .fr_item
  );

  ep0r_queue u_queue (
    .clk, .rst_n,
    .wr_valid (fr_valid), .wr_ready (fr_ready), .wr_item (fr_item),
    .rd_valid (q_valid),  .rd_ready (q_ready),  .rd_item (q_item)
  );

  ep0r_exec u_exec (
    .clk, .rst_n, .cfg (cfg_r), .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_action, .out_endpoint_address, .out_byte_count,
    .out_reply_word, .out_device_state_out, .out_last
  );

`ifndef SYNTHESIS
  // Nothing is delivered in the cycle after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A none action is always the only word of its item
  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ep0r_pkg::ACT_NONE |-> out_last)
    else $error("none action not marked last");

  // Words of one item follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside an item's result words");

  // All words of one item report the same device state
  a_same_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> $stable(out_device_state_out))
    else $error("device state changed within an item");
`endif

endmodule

[tb/tb_usb_device_ep0_request_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_device_ep0_request_engine_core
// Self-checking bench for the EP0 request engine. A directed table of events
// is followed by random enumeration-like sequences. Every accepted event is
// run through a behavioural model of the engine, and the action words it
// yields are queued and compared, field by field, with the block's output.
// ----------------------------------------------------------------------------
module tb_usb_device_ep0_request_engine_core;

  // Opcode that the engine does not use
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // Fields of one action word: action, address, count, reply, device state, last
  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  addr;
    logic [15:0] count;
    logic [15:0] reply;
    logic [1:0]  dstate;
    logic        last;
  } action_word_t;

  // One event item
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic [3:0]  epn;
    logic        class_ok;
    logic        desc_present;
    logic [15:0] desc_length;
  } event_t;

  // Directed row: event, and optionally the single expected word
  typedef struct packed {
    event_t       ev;
    logic         typed;
    action_word_t word;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  event_t      drv = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_action;
  logic [7:0]  out_endpoint_address;
  logic [15:0] out_byte_count;
  logic [15:0] out_reply_word;
  logic [1:0]  out_device_state_out;
  logic        out_last;

  usb_device_ep0_request_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(drv.op), .in_request_type(drv.rtype), .in_request_code(drv.code),
    .in_request_value(drv.value), .in_request_index(drv.index),
    .in_request_length(drv.length), .in_endpoint_number(drv.epn),
    .in_class_ok(drv.class_ok), .in_desc_present(drv.desc_present),
    .in_desc_length(drv.desc_length),
    .out_valid(out_valid), .out_ready(out_ready), .out_action(out_action),
    .out_endpoint_address(out_endpoint_address), .out_byte_count(out_byte_count),
    .out_reply_word(out_reply_word), .out_device_state_out(out_device_state_out),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Model copy of configuration and state
  logic        m_self_powered, m_high_speed;
  logic [15:0] m_in_used, m_out_used;
  logic [7:0]  m_max_if, m_max_cfg;
  logic [1:0]  m_dev, m_saved;
  logic [2:0]  m_stage;
  logic [7:0]  m_cfg_val;
  logic [6:0]  m_addr;
  logic        m_wakeup, m_test;
  logic [15:0] m_exp_len, m_in_rem, m_in_tot, m_out_rem;
  logic [31:0] m_halt;

  action_word_t pend[$];
  action_word_t expected_actions[$];
  int           mismatches = 0;
  bit           hold_off = 1'b0;

  // Staging of the words of one event
  task automatic add_word(input logic [3:0] a, input logic [7:0] ad,
                          input logic [15:0] c, input logic [15:0] r);
    action_word_t w;
    if (pend.size() < 4) begin
      w = '0;
      w.action = a; w.addr = ad; w.count = c; w.reply = r;
      pend.push_back(w);
    end
  endtask

  task automatic add_stall_pair();
    add_word(ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
    add_word(ep0r_pkg::ACT_STALL, 8'h00, 16'd0, 16'd0);
  endtask

  task automatic enter_status_in();
    m_stage = ep0r_pkg::STG_STATUS_IN;
    add_word(ep0r_pkg::ACT_STATUS_IN, 8'h80, 16'd0, 16'd0);
  endtask

  task automatic start_send(input logic [15:0] len, input logic [15:0] r);
    m_stage = ep0r_pkg::STG_DATA_IN;
    m_in_rem = len;
    m_in_tot = len;
    add_word(ep0r_pkg::ACT_SEND, 8'h80, len, r);
  endtask

  function automatic logic [31:0] ep_flag(input logic [7:0] ep);
    logic [31:0] b;
    b = 32'd0;
    if (ep[3:0] != 4'd0) b[ep[7] ? 5'(ep[3:0]) + 5'd16 : 5'(ep[3:0])] = 1'b1;
    return b;
  endfunction

  task automatic class_hand_off(input logic [7:0] rtype, input logic [15:0] wlen,
                                input logic ok);
    add_word(ep0r_pkg::ACT_CLS_SETUP, 8'h00, 16'd0, 16'd0);
    if (ok && wlen != 0 && !rtype[7]) begin
      m_stage = ep0r_pkg::STG_DATA_OUT;
      m_out_rem = wlen;
      add_word(ep0r_pkg::ACT_RECEIVE, 8'h00,
               (wlen < ep0r_pkg::EP0_PACKET) ? wlen : ep0r_pkg::EP0_PACKET, 16'd0);
    end
  endtask

  task automatic model_set_config(input logic [7:0] c, input logic ok);
    if (c > m_max_cfg) begin
      add_stall_pair();
    end else if (m_dev == ep0r_pkg::ST_ADDRESSED) begin
      if (c == 0) begin
        enter_status_in();
      end else begin
        m_cfg_val = c; m_dev = ep0r_pkg::ST_CONFIGURED;
        add_word(ep0r_pkg::ACT_CLS_INIT, 8'h00, 16'd0, {8'd0, c});
        if (!ok) begin
          m_cfg_val = '0; m_dev = ep0r_pkg::ST_ADDRESSED; add_stall_pair();
        end else enter_status_in();
      end
    end else if (m_dev == ep0r_pkg::ST_CONFIGURED) begin
      if (c == 0) begin
        add_word(ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0, {8'd0, m_cfg_val});
        m_cfg_val = '0; m_dev = ep0r_pkg::ST_ADDRESSED;
        enter_status_in();
      end else if (c != m_cfg_val) begin
        add_word(ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0, {8'd0, m_cfg_val});
        m_cfg_val = c;
        add_word(ep0r_pkg::ACT_CLS_INIT, 8'h00, 16'd0, {8'd0, c});
        if (!ok) begin
          m_cfg_val = '0; m_dev = ep0r_pkg::ST_ADDRESSED; add_stall_pair();
        end else enter_status_in();
      end else enter_status_in();
    end else begin
      add_stall_pair();
      add_word(ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0, {8'd0, c});
    end
  endtask

  task automatic model_device_request(input event_t e);
    logic       susp;
    logic [7:0] dtype, didx;
    logic       ok;
    susp = (m_dev == ep0r_pkg::ST_SUSPENDED);
    case (e.code)
      ep0r_pkg::REQ_GET_DESC: begin
        dtype = e.value[15:8]; didx = e.value[7:0];
        if (dtype == 8'd1 || dtype == 8'd2) ok = 1'b1;
        else if (dtype == 8'd3) ok = (didx <= 8'd5);
        else if (dtype == 8'd6 || dtype == 8'd7) ok = m_high_speed;
        else ok = 1'b0;
        if (!ok || !e.desc_present || (e.desc_length == 0 && e.length != 0))
          add_stall_pair();
        else if (e.length == 0) enter_status_in();
        else start_send((e.desc_length < e.length) ? e.desc_length : e.length, 16'd0);
      end
      ep0r_pkg::REQ_SET_ADDRESS: begin
        if (m_dev == ep0r_pkg::ST_CONFIGURED || e.index != 0 || e.length != 0 ||
            e.value > 16'h7F) begin
          add_stall_pair();
        end else begin
          m_addr = e.value[6:0];
          add_word(ep0r_pkg::ACT_SET_ADDR, 8'h00, 16'd0, {9'd0, m_addr});
          enter_status_in();
          m_dev = (m_addr != 0) ? ep0r_pkg::ST_ADDRESSED : ep0r_pkg::ST_DEFAULT;
        end
      end
      ep0r_pkg::REQ_SET_CONFIG: model_set_config(e.value[7:0], e.class_ok);
      ep0r_pkg::REQ_GET_CONFIG: begin
        if (e.length != 1 || susp) add_stall_pair();
        else start_send(16'd1, (m_dev == ep0r_pkg::ST_CONFIGURED) ? {8'd0, m_cfg_val}
                                                                 : 16'd0);
      end
      ep0r_pkg::REQ_GET_STATUS: begin
        if (e.length != 2 || susp) add_stall_pair();
        else start_send(16'd2, {14'd0, m_wakeup, m_self_powered});
      end
      ep0r_pkg::REQ_SET_FEATURE: begin
        if (e.value == 1) begin
          m_wakeup = 1'b1; enter_status_in();
        end else if (e.value == 2) begin
          m_test = 1'b1; enter_status_in();
        end else add_stall_pair();
      end
      ep0r_pkg::REQ_CLEAR_FEATURE: begin
        if (!susp && e.value == 1) begin
          m_wakeup = 1'b0; enter_status_in();
        end else add_stall_pair();
      end
      default: add_stall_pair();
    endcase
  endtask

  task automatic model_endpoint_request(input event_t e);
    logic [7:0]  ep;
    logic        ep0;
    logic [15:0] mask;
    ep = e.index[7:0];
    ep0 = (ep == 8'h00 || ep == 8'h80);
    if (e.code == ep0r_pkg::REQ_SET_FEATURE || e.code == ep0r_pkg::REQ_CLEAR_FEATURE) begin
      if (m_dev == ep0r_pkg::ST_ADDRESSED) begin
        if (!ep0) begin
          add_word(ep0r_pkg::ACT_STALL, ep, 16'd0, 16'd0);
          add_word(ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
        end else add_stall_pair();
      end else if (m_dev == ep0r_pkg::ST_CONFIGURED) begin
        if (e.code == ep0r_pkg::REQ_SET_FEATURE) begin
          if (e.value == 0 && !ep0 && e.length == 0) begin
            m_halt |= ep_flag(ep);
            add_word(ep0r_pkg::ACT_STALL, ep, 16'd0, 16'd0);
          end
          enter_status_in();
        end else if (e.value == 0) begin
          if (ep[6:0] != 0) begin
            m_halt &= ~ep_flag(ep);
            add_word(ep0r_pkg::ACT_CLEAR_STALL, ep, 16'd0, 16'd0);
          end
          enter_status_in();
        end
      end else add_stall_pair();
    end else if (e.code == ep0r_pkg::REQ_GET_STATUS) begin
      if (m_dev == ep0r_pkg::ST_ADDRESSED) begin
        if (!ep0) add_stall_pair();
        else start_send(16'd2, 16'd0);
      end else if (m_dev == ep0r_pkg::ST_CONFIGURED) begin
        mask = ep[7] ? m_in_used : m_out_used;
        if (!mask[ep[3:0]]) add_stall_pair();
        else start_send(16'd2, (!ep0 && (m_halt & ep_flag(ep)) != 0) ? 16'd1 : 16'd0);
      end else add_stall_pair();
    end else add_stall_pair();
  endtask

  task automatic model_setup(input event_t e);
    logic [1:0] kind;
    logic [4:0] recip;
    kind = e.rtype[6:5];
    recip = e.rtype[4:0];
    m_stage = ep0r_pkg::STG_SETUP;
    m_exp_len = e.length;
    if (recip > 2) begin
      add_word(ep0r_pkg::ACT_STALL, {e.rtype[7], 7'd0}, 16'd0, 16'd0);
    end else if (kind == 2'd3) begin
      add_stall_pair();
    end else if (recip == 1) begin
      if (m_dev == ep0r_pkg::ST_SUSPENDED || e.index[7:0] > m_max_if) begin
        add_stall_pair();
      end else begin
        class_hand_off(e.rtype, e.length, e.class_ok);
        if (e.length == 0 && e.class_ok) enter_status_in();
      end
    end else if (kind != 0) class_hand_off(e.rtype, e.length, e.class_ok);
    else if (recip == 0) model_device_request(e);
    else model_endpoint_request(e);
  endtask

  task automatic model_out_done(input logic [3:0] ep);
    if (ep != 0) begin
      if (m_dev == ep0r_pkg::ST_CONFIGURED)
        add_word(ep0r_pkg::ACT_CLS_DATA, {4'd0, ep}, 16'd0, 16'd0);
    end else if (m_stage == ep0r_pkg::STG_DATA_OUT) begin
      if (m_out_rem > ep0r_pkg::EP0_PACKET) begin
        m_out_rem = m_out_rem - ep0r_pkg::EP0_PACKET;
        add_word(ep0r_pkg::ACT_RECEIVE, 8'h00,
                 (m_out_rem < ep0r_pkg::EP0_PACKET) ? m_out_rem : ep0r_pkg::EP0_PACKET,
                 16'd0);
      end else begin
        if (m_dev == ep0r_pkg::ST_CONFIGURED)
          add_word(ep0r_pkg::ACT_RX_READY, 8'h00, 16'd0, 16'd0);
        enter_status_in();
      end
    end else if (m_stage == ep0r_pkg::STG_STATUS_OUT) begin
      m_stage = ep0r_pkg::STG_IDLE;
      add_word(ep0r_pkg::ACT_STALL, 8'h00, 16'd0, 16'd0);
    end
  endtask

  task automatic model_in_done(input logic [3:0] ep);
    if (ep != 0) begin
      if (m_dev == ep0r_pkg::ST_CONFIGURED)
        add_word(ep0r_pkg::ACT_CLS_DATA, {4'h8, ep}, 16'd0, 16'd0);
      return;
    end
    if (m_stage == ep0r_pkg::STG_DATA_IN) begin
      if (m_in_rem > ep0r_pkg::EP0_PACKET) begin
        m_in_rem = m_in_rem - ep0r_pkg::EP0_PACKET;
        add_word(ep0r_pkg::ACT_CONT_SEND, 8'h80, m_in_rem, 16'd0);
        add_word(ep0r_pkg::ACT_RECEIVE, 8'h00, 16'd0, 16'd0);
      end else if (m_in_tot[5:0] == 0 && m_in_tot >= ep0r_pkg::EP0_PACKET &&
                   m_in_tot < m_exp_len) begin
        add_word(ep0r_pkg::ACT_CONT_SEND, 8'h80, 16'd0, 16'd0);
        m_exp_len = '0;
        add_word(ep0r_pkg::ACT_RECEIVE, 8'h00, 16'd0, 16'd0);
      end else begin
        if (m_dev == ep0r_pkg::ST_CONFIGURED)
          add_word(ep0r_pkg::ACT_TX_SENT, 8'h80, 16'd0, 16'd0);
        add_word(ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
        m_stage = ep0r_pkg::STG_STATUS_OUT;
        add_word(ep0r_pkg::ACT_STATUS_OUT, 8'h00, 16'd0, 16'd0);
      end
    end else if (m_stage == ep0r_pkg::STG_STATUS_IN || m_stage == ep0r_pkg::STG_IDLE) begin
      add_word(ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0);
    end
    m_test = 1'b0;
  endtask

  task automatic clear_device_state();
    m_dev = ep0r_pkg::ST_DEFAULT; m_saved = ep0r_pkg::ST_DEFAULT;
    m_stage = ep0r_pkg::STG_IDLE;
    m_cfg_val = '0; m_addr = '0; m_wakeup = 1'b0; m_exp_len = '0; m_in_rem = '0;
    m_in_tot = '0; m_out_rem = '0; m_halt = '0; m_test = 1'b0;
  endtask

  // Works out the words of one event and queues them
  task automatic predict_actions(input event_t e);
    pend.delete();
    case (e.op)
      ep0r_pkg::OP_BUS_RESET: begin
        if (m_cfg_val != 0)
          add_word(ep0r_pkg::ACT_CLS_DEINIT, 8'h00, 16'd0, {8'd0, m_cfg_val});
        clear_device_state();
      end
      ep0r_pkg::OP_SUSPEND: begin
        if (m_dev != ep0r_pkg::ST_SUSPENDED) m_saved = m_dev;
        m_dev = ep0r_pkg::ST_SUSPENDED;
      end
      ep0r_pkg::OP_RESUME: if (m_dev == ep0r_pkg::ST_SUSPENDED) m_dev = m_saved;
      ep0r_pkg::OP_SETUP: model_setup(e);
      ep0r_pkg::OP_OUT_DONE: model_out_done(e.epn);
      ep0r_pkg::OP_IN_DONE: model_in_done(e.epn);
      ep0r_pkg::OP_SOF:
        if (m_dev == ep0r_pkg::ST_CONFIGURED)
          add_word(ep0r_pkg::ACT_CLS_SOF, 8'h00, 16'd0, 16'd0);
      default: ;
    endcase
    if (pend.size() == 0) add_word(ep0r_pkg::ACT_NONE, 8'h00, 16'd0, 16'd0);
    foreach (pend[k]) begin
      pend[k].dstate = m_dev;
      pend[k].last = (k == pend.size() - 1);
      expected_actions.push_back(pend[k]);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Result side: ready with random gaps and a long hold-off on request, sampled at the rising edge
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compares each accepted word with the oldest expectation
  always @(posedge clk) begin
    action_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        report_mismatch("unexpected word", int'(out_action), 0);
      end else begin
        w = expected_actions.pop_front();
        if (out_action !== w.action)
          report_mismatch("action", int'(out_action), int'(w.action));
        if (out_endpoint_address !== w.addr)
          report_mismatch("endpoint_address", int'(out_endpoint_address), int'(w.addr));
        if (out_byte_count !== w.count)
          report_mismatch("byte_count", int'(out_byte_count), int'(w.count));
        if (out_reply_word !== w.reply)
          report_mismatch("reply_word", int'(out_reply_word), int'(w.reply));
        if (out_device_state_out !== w.dstate)
          report_mismatch("device_state_out", int'(out_device_state_out), int'(w.dstate));
        if (out_last !== w.last) report_mismatch("last", int'(out_last), int'(w.last));
      end
    end
  end

  // Offers one item and waits for its acceptance; prediction at acceptance
  task automatic send_event(input event_t e, input logic typed, input action_word_t tw);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv <= e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_actions(e);
    if (typed && (pend.size() != 1 || pend[0] != tw))
      report_mismatch("directed row prediction", int'(pend[0].action), int'(tw.action));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ep0r_pkg::REG_SELF_POWERED: m_self_powered = val[0];
      ep0r_pkg::REG_HIGH_SPEED:   m_high_speed = val[0];
      ep0r_pkg::REG_IN_USED:      m_in_used = val;
      ep0r_pkg::REG_OUT_USED:     m_out_used = val;
      ep0r_pkg::REG_MAX_IF:       m_max_if = val[7:0];
      default:                    m_max_cfg = val[7:0];
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic event_t mk_setup(input logic [7:0] rt, input logic [7:0] cd,
                                      input logic [15:0] v, input logic [15:0] ix,
                                      input logic [15:0] ln, input logic ok,
                                      input logic dp, input logic [15:0] dl);
    event_t e;
    e = '0;
    e.op = ep0r_pkg::OP_SETUP; e.rtype = rt; e.code = cd; e.value = v; e.index = ix;
    e.length = ln; e.class_ok = ok; e.desc_present = dp; e.desc_length = dl;
    return e;
  endfunction

  function automatic event_t mk_op(input logic [2:0] op, input logic [3:0] ep);
    event_t e;
    e = '0;
    e.op = op; e.epn = ep;
    return e;
  endfunction

  function automatic event_t rand_event();
    event_t e;
    e = event_t'({$urandom, $urandom, $urandom, $urandom});
    return e;
  endfunction

  // Random but mostly well-formed request
  function automatic event_t rand_request();
    event_t e;
    int     pick;
    logic [7:0] cds[7];
    cds = '{ep0r_pkg::REQ_GET_STATUS, ep0r_pkg::REQ_CLEAR_FEATURE, ep0r_pkg::REQ_SET_FEATURE,
            ep0r_pkg::REQ_SET_ADDRESS, ep0r_pkg::REQ_GET_DESC, ep0r_pkg::REQ_GET_CONFIG,
            ep0r_pkg::REQ_SET_CONFIG};
    pick = $urandom_range(0, 19);
    e = mk_setup(8'h00, cds[$urandom_range(0, 6)], 16'($urandom_range(0, 3)), 16'd0,
                 16'($urandom_range(0, 2)), $urandom_range(0, 4) != 0, $urandom_range(0, 5) != 0,
                 16'($urandom_range(0, 200)));
    case (pick)
      0, 1, 2: begin
        e.code = ep0r_pkg::REQ_GET_DESC; e.rtype = 8'h80;
        e.value = {8'($urandom_range(1, 7)), 8'($urandom_range(0, 6))};
        e.length = 16'($urandom_range(0, 300));
      end
      3, 4: begin
        e.code = ep0r_pkg::REQ_SET_ADDRESS; e.value = 16'($urandom_range(0, 127));
        e.length = 16'd0;
      end
      5, 6: begin
        e.code = ep0r_pkg::REQ_SET_CONFIG; e.value = 16'($urandom_range(0, 3));
        e.length = 16'd0;
      end
      7, 8: begin
        e.rtype = {$urandom_range(0, 1) ? 8'h80 : 8'h00} | 8'h02;
        e.code = ($urandom_range(0, 1)) ? ep0r_pkg::REQ_SET_FEATURE
                                        : ep0r_pkg::REQ_CLEAR_FEATURE;
        e.index = 16'($urandom_range(0, 15));
        e.index[7] = 1'($urandom_range(0, 1)); e.value = 16'd0; e.length = 16'd0;
        if (e.code == ep0r_pkg::REQ_CLEAR_FEATURE) e.rtype = 8'h02;
      end
      9: begin
        e.rtype = 8'h82; e.code = ep0r_pkg::REQ_GET_STATUS; e.length = 16'd2;
        e.index = {8'd0, 1'($urandom_range(0, 1)), 3'($urandom), 4'($urandom_range(0, 15))};
      end
      10, 11: begin
        e.rtype = {1'($urandom), 2'($urandom_range(0, 2)), 5'($urandom_range(0, 2))};
        e.length = 16'($urandom_range(0, 200));
        e.index = 16'($urandom_range(0, 3));
        e.code = 8'($urandom);
      end
      12: e = rand_event();
      default: ;
    endcase
    return e;
  endfunction

  // Directed table
  row_t rows[$];
  action_word_t none_def = '{ep0r_pkg::ACT_NONE, 8'h00, 16'd0, 16'd0,
                             ep0r_pkg::ST_DEFAULT, 1'b1};

  initial begin
    event_t e;
    action_word_t tw;
    int     n;
    m_self_powered = 1'b0; m_high_speed = 1'b0; m_in_used = 16'h0001; m_out_used = 16'h0001;
    m_max_if = 8'd1; m_max_cfg = 8'd1;
    clear_device_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes of the registers for the directed part
    write_reg(ep0r_pkg::REG_SELF_POWERED, 16'd1);
    write_reg(ep0r_pkg::REG_HIGH_SPEED, 16'd1);
    write_reg(ep0r_pkg::REG_IN_USED, 16'hFFFF);
    write_reg(ep0r_pkg::REG_OUT_USED, 16'h0000);
    write_reg(ep0r_pkg::REG_MAX_IF, 16'd255);
    write_reg(ep0r_pkg::REG_MAX_CFG, 16'd2);

    // Rows: typed words where obvious, the rest predicted
    rows.push_back('{mk_op(ep0r_pkg::OP_SOF, 4'd0), 1'b1, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_BUS_RESET, 4'd0), 1'b1, none_def});
    tw = '{ep0r_pkg::ACT_STALL, 8'h80, 16'd0, 16'd0, ep0r_pkg::ST_DEFAULT, 1'b1};
    rows.push_back('{mk_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF),
                     1'b1, tw});
    rows.push_back('{mk_setup(8'h60, 8'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 16'd0),
                     1'b0, none_def});
    rows.push_back('{mk_setup(8'h80, ep0r_pkg::REQ_GET_DESC, 16'h0100, 16'd0, 16'hFFFF,
                              1'b1, 1'b1, 16'd200), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_IN_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_IN_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_IN_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_OUT_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h80, ep0r_pkg::REQ_GET_DESC, 16'h0300, 16'd0, 16'd128,
                              1'b1, 1'b1, 16'd128), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_IN_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_IN_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h80, ep0r_pkg::REQ_GET_DESC, 16'h0600, 16'd0, 16'd10,
                              1'b1, 1'b0, 16'd10), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h80, ep0r_pkg::REQ_GET_DESC, 16'h0200, 16'd0, 16'd10,
                              1'b1, 1'b1, 16'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h00, ep0r_pkg::REQ_SET_ADDRESS, 16'd127, 16'd0, 16'd0,
                              1'b1, 1'b1, 16'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h00, ep0r_pkg::REQ_SET_CONFIG, 16'd2, 16'd0, 16'd0,
                              1'b0, 1'b1, 16'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h00, ep0r_pkg::REQ_SET_CONFIG, 16'd2, 16'd0, 16'd0,
                              1'b1, 1'b1, 16'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h02, ep0r_pkg::REQ_SET_FEATURE, 16'd0, 16'h0085, 16'd0,
                              1'b1, 1'b1, 16'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h82, ep0r_pkg::REQ_GET_STATUS, 16'd0, 16'h0085, 16'd2,
                              1'b1, 1'b1, 16'd0), 1'b0, none_def});
    rows.push_back('{mk_setup(8'h21, 8'h09, 16'd0, 16'd0, 16'd130, 1'b1, 1'b1, 16'd0),
                     1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_OUT_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_OUT_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_OUT_DONE, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_SUSPEND, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_SUSPEND, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_RESUME, 4'd15), 1'b0, none_def});
    rows.push_back('{mk_op(OP_UNUSED, 4'd0), 1'b0, none_def});
    rows.push_back('{mk_op(ep0r_pkg::OP_BUS_RESET, 4'd0), 1'b0, none_def});
    foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].word);
    drain();

    // Random phases under varied settings, the first one with a long hold-off
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ep0r_pkg::REG_SELF_POWERED, 16'($urandom_range(0, 1)));
      write_reg(ep0r_pkg::REG_HIGH_SPEED, 16'($urandom_range(0, 1)));
      write_reg(ep0r_pkg::REG_IN_USED, (ph == 3) ? 16'hFFFF : 16'($urandom));
      write_reg(ep0r_pkg::REG_OUT_USED, (ph == 3) ? 16'h0000 : 16'($urandom));
      write_reg(ep0r_pkg::REG_MAX_IF, (ph == 2) ? 16'd0 : 16'($urandom_range(0, 255)));
      write_reg(ep0r_pkg::REG_MAX_CFG, (ph == 2) ? 16'd255 : 16'($urandom_range(0, 3)));
      if (ph == 0) hold_off = 1'b1;
      n = 0;
      while (n < 38) begin
        case ($urandom_range(0, 9))
          0: e = mk_op(ep0r_pkg::OP_BUS_RESET, 4'($urandom));
          1: e = mk_op($urandom_range(0, 1) ? ep0r_pkg::OP_SUSPEND : ep0r_pkg::OP_RESUME,
                       4'($urandom));
          2: e = mk_op(ep0r_pkg::OP_SOF, 4'($urandom));
          3: e = mk_op(ep0r_pkg::OP_OUT_DONE, $urandom_range(0, 2) ? 4'd0 : 4'($urandom));
          4, 5: e = mk_op(ep0r_pkg::OP_IN_DONE, $urandom_range(0, 3) ? 4'd0 : 4'($urandom));
          6: e = rand_event();
          default: e = rand_request();
        endcase
        send_event(e, 1'b0, none_def);
        n++;
      end
      drain();
    end

    if (mismatches == 0 && expected_actions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
